/* rtl/core/whf_pkg.sv */
// Package for the waypoint heading follower: shared types, register map and CORDIC table.
// No dependencies.
package whf_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned AngleW = 16;
  localparam int unsigned AddrW  = 5;

  // Register byte addresses
  localparam logic [AddrW-1:0] RegMaxLin  = 5'd0;
  localparam logic [AddrW-1:0] RegMinLin  = 5'd4;
  localparam logic [AddrW-1:0] RegMaxTurn = 5'd8;
  localparam logic [AddrW-1:0] RegGain    = 5'd12;
  localparam logic [AddrW-1:0] RegTol     = 5'd16;
  localparam logic [AddrW-1:0] RegTip     = 5'd20;
  localparam logic [AddrW-1:0] RegRecip   = 5'd24;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic [11:0] max_lin;
    logic [11:0] min_lin;
    logic [12:0] max_turn;
    logic [15:0] gain;
    logic [14:0] tol;
    logic [14:0] tip;
    logic [23:0] recip;
  } cfg_t;

  function automatic logic [13:0] atan_entry(input logic [4:0] i);
    logic [13:0] v;
    case (i)
      5'd0:  v = 14'd8192;
      5'd1:  v = 14'd4836;
      5'd2:  v = 14'd2555;
      5'd3:  v = 14'd1297;
      5'd4:  v = 14'd651;
      5'd5:  v = 14'd326;
      5'd6:  v = 14'd163;
      5'd7:  v = 14'd81;
      5'd8:  v = 14'd41;
      5'd9:  v = 14'd20;
      5'd10: v = 14'd10;
      5'd11: v = 14'd5;
      5'd12: v = 14'd3;
      5'd13: v = 14'd1;
      5'd14: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/whf_regs.sv */
// Configuration register file for the waypoint heading follower, APB-style write/read.
// Depends on whf_pkg.
module whf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [whf_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output whf_pkg::cfg_t              cfg
);

  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_lin  <= 12'd400;
      cfg.min_lin  <= 12'd50;
      cfg.max_turn <= 13'd400;
      cfg.gain     <= 16'd6283;
      cfg.tol      <= 15'd1565;
      cfg.tip      <= 15'd7301;
      cfg.recip    <= 24'd3217;
    end else if (wr) begin
      case (paddr)
        whf_pkg::RegMaxLin:  cfg.max_lin  <= pwdata[11:0];
        whf_pkg::RegMinLin:  cfg.min_lin  <= pwdata[11:0];
        whf_pkg::RegMaxTurn: cfg.max_turn <= pwdata[12:0];
        whf_pkg::RegGain:    cfg.gain     <= pwdata[15:0];
        whf_pkg::RegTol:     cfg.tol      <= pwdata[14:0];
        whf_pkg::RegTip:     cfg.tip      <= pwdata[14:0];
        whf_pkg::RegRecip:   cfg.recip    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      whf_pkg::RegMaxLin:  prdata = {20'd0, cfg.max_lin};
      whf_pkg::RegMinLin:  prdata = {20'd0, cfg.min_lin};
      whf_pkg::RegMaxTurn: prdata = {19'd0, cfg.max_turn};
      whf_pkg::RegGain:    prdata = {16'd0, cfg.gain};
      whf_pkg::RegTol:     prdata = {17'd0, cfg.tol};
      whf_pkg::RegTip:     prdata = {17'd0, cfg.tip};
      whf_pkg::RegRecip:   prdata = {8'd0, cfg.recip};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/waypoint_heading_follower.sv */
// Waypoint heading follower: a load request leaves the block idle, so loads may follow back to back.
// A tick with missing data (empty path, no valid pose or not tracking) goes straight to S_DONE.
// A full tick squares the distance to each waypoint on the shared multiplier, then reads the
// target and runs the CORDIC, heading error and speed states. The input stays stalled until a
// tick's result enters the output register, also while out_stall holds it back. Synchronous
// reset restores path length, out_valid, state and configuration; the waypoint memory is not cleared.
module waypoint_heading_follower #(
  parameter int unsigned MAX_WAYPOINTS = 64,
  parameter int unsigned CORDIC_STEPS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic               new_path,
  input  logic signed [23:0] waypoint_x,
  input  logic signed [23:0] waypoint_y,
  input  logic signed [23:0] robot_x,
  input  logic signed [23:0] robot_y,
  input  logic signed [15:0] robot_yaw,
  input  logic               pose_valid,
  input  logic               tracking,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        linear_speed,
  output logic signed [13:0] turn_rate,
  output logic [5:0]         target_index,
  output logic               held
);

  localparam int unsigned IdxW  = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned LenW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned Steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int unsigned StepW = 5;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_WAYPOINTS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RD    = 12'b000000000010,  // memory read issued
    S_SQX   = 12'b000000000100,  // waypoint deltas
    S_SQY   = 12'b000000001000,  // square dx
    S_TRD   = 12'b000000010000,  // read target
    S_TDIF  = 12'b000000100000,  // square dy, compare, advance
    S_CPRE  = 12'b000001000000,  // target deltas, CORDIC setup
    S_CIT   = 12'b000010000000,  // CORDIC prerotation and iterations
    S_ERR   = 12'b000100000000,  // heading error
    S_MUL1  = 12'b001000000000,  // mag * recip, then gain * mag
    S_MUL2  = 12'b010000000000,  // max * ratio
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  whf_pkg::cfg_t cfg;
  assign pready = 1'b1;

  whf_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  // Path memory
  logic [2*whf_pkg::CoordW-1:0] path_mem [MAX_WAYPOINTS];
  logic [2*whf_pkg::CoordW-1:0] rd_data;
  logic [IdxW-1:0]              rd_addr;
  logic [LenW-1:0]              path_length;
  logic                         wr_en;
  logic [IdxW-1:0]              wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) path_mem[wr_addr] <= {waypoint_x, waypoint_y};
    rd_data <= path_mem[rd_addr];
  end

  // Request latch
  logic signed [23:0] rx, ry;
  logic [15:0]        yaw;
  logic               accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Scan state
  logic [LenW-1:0]    idx;
  logic [IdxW-1:0]    nearest;
  logic [48:0]        best, dsq;
  logic signed [24:0] dx, dy;
  logic [LenW-1:0]    target;

  // Shared multiplier: 26x26 signed, used for squares and speed and turn-rate math
  logic signed [25:0] ma, mb;
  logic signed [51:0] mp;
  assign mp = ma * mb;

  // CORDIC
  logic signed [27:0]  cx, cy;
  logic signed [17:0]  cz;
  logic [StepW-1:0]    step;
  logic signed [15:0]  err;
  logic [16:0]         mag;
  logic signed [41:0]  ratio;
  logic [32:0]         rate_raw;

  // Finished result, held here until the output register is free
  logic [11:0]         res_speed;
  logic signed [13:0]  res_rate;
  logic [5:0]          res_target;
  logic                res_held;
  logic                out_load;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQY:  begin ma = 26'(dx); mb = 26'(dx); end
      S_TDIF: begin ma = 26'(dy); mb = 26'(dy); end
      S_MUL1: begin
        ma = $signed({9'd0, mag});
        if (idx == LenW'(2)) mb = $signed({10'd0, cfg.gain});
        else mb = $signed({2'd0, cfg.recip});
      end
      S_MUL2: begin ma = $signed({14'd0, cfg.max_lin}); mb = ratio[25:0]; end
      default: ;
    endcase
  end

  always_comb begin
    rd_addr = idx[IdxW-1:0];
    if (state == S_TRD || (state == S_SQY && 1'b0)) rd_addr = target[IdxW-1:0];
  end

  assign wr_en   = accept && (command == whf_pkg::CmdLoad) &&
                   (new_path || path_length < MaxLen);
  assign wr_addr = new_path ? '0 : path_length[IdxW-1:0];

  logic signed [27:0] xs, ys;
  logic [13:0]        at;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = whf_pkg::atan_entry(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      path_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Move the finished result to the output, or drop valid once it is taken
      if (out_load) begin
        out_valid    <= 1'b1;
        linear_speed <= res_speed;
        turn_rate    <= res_rate;
        target_index <= res_target;
        held         <= res_held;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rx  <= robot_x;
            ry  <= robot_y;
            yaw <= robot_yaw;
            idx <= '0;
            if (command == whf_pkg::CmdLoad) begin
              if (wr_en) path_length <= new_path ? LenW'(1) : path_length + LenW'(1);
            end else if (path_length == '0 || !pose_valid || !tracking) begin
              res_speed  <= '0;
              res_rate   <= '0;
              res_target <= '0;
              res_held   <= 1'b1;
              state      <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          // read data for idx arrives next cycle
          state <= S_SQX;
        end
        S_SQX: begin
          dx    <= 25'($signed(rd_data[47:24])) - 25'(rx);
          dy    <= 25'($signed(rd_data[23:0])) - 25'(ry);
          state <= S_SQY;
        end
        S_SQY: begin
          dsq   <= mp[48:0];
          state <= S_TDIF;
        end
        S_TDIF: begin
          // finish distance, compare, advance
          if (idx == '0 || (dsq + mp[48:0]) < best) begin
            best    <= dsq + mp[48:0];
            nearest <= idx[IdxW-1:0];
          end
          if (idx + LenW'(1) < path_length) begin
            idx   <= idx + LenW'(1);
            state <= S_RD;
          end else begin
            state <= S_TRD;
          end
        end
        S_TRD: begin
          state <= S_CPRE;
        end
        S_CPRE: begin
          // rd_data now holds target
          dx   <= 25'($signed(rd_data[47:24])) - 25'(rx);
          dy   <= 25'($signed(rd_data[23:0])) - 25'(ry);
          step <= '0;
          state <= S_CIT;
          cz   <= '0;
          cx   <= '0;
          cy   <= '0;
          idx  <= '0;
        end
        S_CIT: begin
          if (idx == '0) begin
            // prerotation
            idx <= LenW'(1);
            if (dx < 0) begin
              if (dy >= 0) begin cx <= 28'(dy); cy <= -28'(dx); cz <= 18'sd16384; end
              else begin cx <= -28'(dy); cy <= 28'(dx); cz <= -18'sd16384; end
            end else begin
              cx <= 28'(dx); cy <= 28'(dy);
            end
          end else begin
            if (cy > 0) begin
              cx <= cx + ys; cy <= cy - xs; cz <= cz + 18'($signed({1'b0, at}));
            end else begin
              cx <= cx - ys; cy <= cy + xs; cz <= cz - 18'($signed({1'b0, at}));
            end
            if (step == StepW'(Steps - 1)) state <= S_ERR;
            else step <= step + StepW'(1);
          end
        end
        S_ERR: begin
          if (dx == '0 && dy == '0) err <= 16'(16'd0 - yaw);
          else err <= 16'(cz[15:0] - yaw);
          state <= S_MUL1;
          idx   <= '0;
        end
        S_MUL1: begin
          if (idx == '0) begin
            mag <= err[15] ? 17'(-$signed({err[15], err})) : {1'b0, err};
            idx <= LenW'(1);
          end else if (idx == LenW'(1)) begin
            ratio <= 42'sd16777216 - 42'(mp);
            idx   <= LenW'(2);
          end else begin
            rate_raw <= mp[32:0];
            state    <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mag > {2'd0, cfg.tip}) begin
            res_speed <= '0;
          end else if (mag > {2'd0, cfg.tol}) begin
            if (ratio <= 0 || 12'(mp >>> 24) < cfg.min_lin) res_speed <= cfg.min_lin;
            else res_speed <= 12'(mp >>> 24);
          end else begin
            res_speed <= cfg.max_lin;
          end
          if ((rate_raw >> 16) > 33'(cfg.max_turn))
            res_rate <= err[15] ? -14'($signed({1'b0, cfg.max_turn}))
                                : 14'($signed({1'b0, cfg.max_turn}));
          else
            res_rate <= err[15] ? -14'(rate_raw[29:16]) : 14'(rate_raw[29:16]);
          res_target <= 6'(target);
          res_held   <= 1'b0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    target = (LenW'(nearest) + LenW'(1) < path_length) ? LenW'(nearest) + LenW'(1)
                                                       : path_length - LenW'(1);
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall || !in_valid ||
                   $past(command) == whf_pkg::CmdLoad)
    else $error("tick accepted without busy");
  assert property (@(posedge clk) disable iff (rst) path_length <= MaxLen)
    else $error("path overflow");
  assert property (@(posedge clk) disable iff (rst) (state == S_DONE && !out_stall) |=> out_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> $stable(turn_rate))
    else $error("result changed while stalled");

endmodule
